// ===== rtl/e2lct_pkg.sv =====
// Constants and types for the epoch to local civil time converter.
// Holds the reciprocal constants of the division stages and the month start table.
// No dependencies.
`default_nettype none

package e2lct_pkg;

    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [19:0] DAY_SHIFT      = 20'd719468;
    localparam logic [19:0] ERA5_START     = 20'd730485;   // 5 * 146097
    localparam logic [19:0] ERA4_START     = 20'd584388;   // 4 * 146097
    localparam logic [17:0] DAYS_PER_4Y    = 18'd1460;
    localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
    localparam logic [17:0] LAST_DAY_OF_ERA = 18'd146096;
    localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN   = 12'd60;

    // floor(2^s / d); the quotient estimate is low by at most one
    localparam logic [15:0] RECIP_DAY   = 16'd49710;     // s = 32
    localparam logic [17:0] RECIP_WEEK  = 18'd149796;    // s = 20
    localparam logic [8:0]  RECIP_HOUR  = 9'd291;        // s = 20
    localparam logic [21:0] RECIP_4Y    = 22'd2941758;   // s = 32
    localparam logic [10:0] RECIP_MIN   = 11'd1092;      // s = 16
    localparam logic [23:0] RECIP_YEAR  = 24'd11767033;  // s = 32

    localparam logic [11:0] YEAR_ERA4 = 12'd1600;
    localparam logic [11:0] YEAR_ERA5 = 12'd2000;

    localparam int NUM_STAGES = 10;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } civil_t;

    // first day of year of each month, year starting in March
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/epoch_to_local_civil_time.sv =====
// Converts a 32-bit UTC Unix time plus a signed zone offset in minutes into local
// civil date, time of day and weekday (0 = Sunday). Takes one word per clock
// unless the output stalls. Results pass through the ten-stage chain
// of reciprocal-multiply divisions (estimate stage, then correction stage). A
// negative local time reads as 1970-01-01 00:00:00; a local time past 2^32-1
// wraps. The offset register must be written while the block is idle.
// Depends on e2lct_pkg.
`default_nettype none

module epoch_to_local_civil_time (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,       // zone_offset_minutes, signed
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,    // [31:0] epoch_utc
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata     // year[11:0] month[15:12] day[20:16]
                                              // hour[25:21] minute[31:26]
                                              // second[37:32] weekday[40:38]
);

    localparam int NS = e2lct_pkg::NUM_STAGES;

    logic signed [10:0] zone_offset_reg;
    logic               skid_vld_reg, skid_vld_next;
    logic [31:0]        skid_data_reg;
    logic [NS-1:0]      vld_reg, vld_next;
    logic               en;
    logic               src_vld;
    logic [31:0]        src_data;

    // stage payloads
    logic [31:0] s1_t_reg, s1_t_next;
    logic [31:0] s2_t_reg;
    logic [15:0] s2_dq_reg, s2_dq_next;
    logic [15:0] s3_days_reg, s3_days_next;
    logic [16:0] s3_secs_reg, s3_secs_next;
    logic [17:0] s4_doe_reg, s4_doe_next;
    logic        s4_era5_reg, s4_era5_next;
    logic [16:0] s4_d4_reg, s4_d4_next;
    logic [12:0] s4_wq_reg, s4_wq_next;
    logic [16:0] s4_secs_reg;
    logic [4:0]  s4_hq_reg, s4_hq_next;
    logic [17:0] s5_doe_reg;
    logic        s5_era5_reg;
    logic [6:0]  s5_q4y_reg, s5_q4y_next;
    logic [2:0]  s5_c100y_reg, s5_c100y_next;
    logic        s5_last_reg, s5_last_next;
    logic [2:0]  s5_wd_reg, s5_wd_next;
    logic [4:0]  s5_hour_reg, s5_hour_next;
    logic [11:0] s5_rem_reg, s5_rem_next;
    logic [17:0] s6_doe_reg;
    logic        s6_era5_reg;
    logic [17:0] s6_n_reg, s6_n_next;
    logic [2:0]  s6_wd_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_rem_reg;
    logic [5:0]  s6_mq_reg, s6_mq_next;
    logic [17:0] s7_doe_reg;
    logic        s7_era5_reg;
    logic [17:0] s7_n_reg;
    logic [8:0]  s7_ye_reg, s7_ye_next;
    logic [2:0]  s7_wd_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg, s7_min_next;
    logic [5:0]  s7_sec_reg, s7_sec_next;
    logic [17:0] s8_doe_reg;
    logic        s8_era5_reg;
    logic [8:0]  s8_yoe_reg, s8_yoe_next;
    logic [2:0]  s8_wd_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic        s9_era5_reg;
    logic [8:0]  s9_yoe_reg;
    logic [8:0]  s9_doy_reg, s9_doy_next;
    logic [2:0]  s9_wd_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [5:0]  s9_sec_reg;
    e2lct_pkg::civil_t s10_out_reg, s10_out_next;

    // combinational temporaries
    logic signed [17:0] off_ext, off_secs;
    logic signed [33:0] local_secs;
    logic [47:0] p2;
    logic [31:0] p3, r3;
    logic [17:0] r3_low;
    logic [19:0] z4;
    logic [34:0] p4_wk;
    logic [25:0] p4_hr;
    logic [39:0] p5_4y;
    logic [16:0] r5_wk, r5_hr;
    logic [17:0] r6_4y;
    logic [6:0]  q4y_fix;
    logic [22:0] p6_min;
    logic [41:0] p7_yr;
    logic [11:0] r7_min;
    logic [17:0] r8_yr;
    logic [1:0]  c100;
    logic [17:0] ydays, r9;
    logic [3:0]  mp;
    logic [8:0]  ms;
    logic [3:0]  mon;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zone_offset_reg <= '0;
        else if (cfg_we)
            zone_offset_reg <= $signed(cfg_wdata);
    end

    // input skid: hold one word while the pipeline stalls
    assign s_axis_tready = !skid_vld_reg;
    assign en            = !vld_reg[NS-1] || m_axis_tready;
    assign src_vld       = skid_vld_reg || s_axis_tvalid;
    assign src_data      = skid_vld_reg ? skid_data_reg : s_axis_tdata;
    assign skid_vld_next = skid_vld_reg ? !en : (s_axis_tvalid && !en);
    assign vld_next      = {vld_reg[NS-2:0], src_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
            if (en)
                vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg && !en)
            skid_data_reg <= s_axis_tdata;
    end

    always_comb
    begin
        // stage 1: apply offset, clamp at zero, wrap at 2^32
        off_ext    = 18'(zone_offset_reg);
        off_secs   = (off_ext <<< 6) - (off_ext <<< 2);
        local_secs = $signed({2'b00, src_data}) + 34'(off_secs);
        s1_t_next  = local_secs[33] ? 32'd0 : local_secs[31:0];

        // stage 2: day quotient estimate
        p2         = 48'(s1_t_reg) * 48'(e2lct_pkg::RECIP_DAY);
        s2_dq_next = p2[47:32];

        // stage 3: correct days, split off seconds of day
        p3     = 32'(s2_dq_reg) * 32'(e2lct_pkg::SECS_PER_DAY);
        r3     = s2_t_reg - p3;
        r3_low = r3[17:0];
        if (r3_low >= 18'(e2lct_pkg::SECS_PER_DAY))
        begin
            s3_days_next = s2_dq_reg + 16'd1;
            s3_secs_next = 17'(r3_low - 18'(e2lct_pkg::SECS_PER_DAY));
        end
        else
        begin
            s3_days_next = s2_dq_reg;
            s3_secs_next = r3_low[16:0];
        end

        // stage 4: era and day of era; weekday and hour estimates
        z4           = 20'(s3_days_reg) + e2lct_pkg::DAY_SHIFT;
        s4_era5_next = (z4 >= e2lct_pkg::ERA5_START);
        s4_doe_next  = 18'(z4 - (s4_era5_next ? e2lct_pkg::ERA5_START
                                              : e2lct_pkg::ERA4_START));
        s4_d4_next   = 17'(s3_days_reg) + 17'd4;
        p4_wk        = 35'(s4_d4_next) * 35'(e2lct_pkg::RECIP_WEEK);
        s4_wq_next   = p4_wk[32:20];
        p4_hr        = 26'(s3_secs_reg) * 26'(e2lct_pkg::RECIP_HOUR);
        s4_hq_next   = p4_hr[24:20];

        // stage 5: four-year estimate, century count; fix weekday and hour
        p5_4y         = 40'(s4_doe_reg) * 40'(e2lct_pkg::RECIP_4Y);
        s5_q4y_next   = p5_4y[38:32];
        s5_c100y_next = 3'(s4_doe_reg >= e2lct_pkg::DAYS_PER_100Y)
                      + 3'(s4_doe_reg >= 18'(2 * e2lct_pkg::DAYS_PER_100Y))
                      + 3'(s4_doe_reg >= 18'(3 * e2lct_pkg::DAYS_PER_100Y))
                      + 3'(s4_doe_reg >= e2lct_pkg::LAST_DAY_OF_ERA);
        s5_last_next  = (s4_doe_reg >= e2lct_pkg::LAST_DAY_OF_ERA);
        r5_wk         = s4_d4_reg - 17'(s4_wq_reg) * 17'd7;
        s5_wd_next    = (r5_wk >= 17'd7) ? 3'(r5_wk - 17'd7) : r5_wk[2:0];
        r5_hr         = s4_secs_reg - 17'(s4_hq_reg) * e2lct_pkg::SECS_PER_HOUR;
        if (r5_hr >= e2lct_pkg::SECS_PER_HOUR)
        begin
            s5_hour_next = s4_hq_reg + 5'd1;
            s5_rem_next  = 12'(r5_hr - e2lct_pkg::SECS_PER_HOUR);
        end
        else
        begin
            s5_hour_next = s4_hq_reg;
            s5_rem_next  = r5_hr[11:0];
        end

        // stage 6: fix four-year count, leap-adjusted day count; minute estimate
        r6_4y   = s5_doe_reg - 18'(s5_q4y_reg) * e2lct_pkg::DAYS_PER_4Y;
        q4y_fix = (r6_4y >= e2lct_pkg::DAYS_PER_4Y) ? s5_q4y_reg + 7'd1 : s5_q4y_reg;
        s6_n_next  = s5_doe_reg - 18'(q4y_fix) + 18'(s5_c100y_reg) - 18'(s5_last_reg);
        p6_min     = 23'(s5_rem_reg) * 23'(e2lct_pkg::RECIP_MIN);
        s6_mq_next = p6_min[21:16];

        // stage 7: year of era estimate; fix minute and second
        p7_yr      = 42'(s6_n_reg) * 42'(e2lct_pkg::RECIP_YEAR);
        s7_ye_next = p7_yr[40:32];
        r7_min     = s6_rem_reg - 12'(s6_mq_reg) * e2lct_pkg::SECS_PER_MIN;
        if (r7_min >= e2lct_pkg::SECS_PER_MIN)
        begin
            s7_min_next = s6_mq_reg + 6'd1;
            s7_sec_next = 6'(r7_min - e2lct_pkg::SECS_PER_MIN);
        end
        else
        begin
            s7_min_next = s6_mq_reg;
            s7_sec_next = r7_min[5:0];
        end

        // stage 8: fix year of era
        r8_yr       = s7_n_reg - 18'(s7_ye_reg) * e2lct_pkg::DAYS_PER_YEAR;
        s8_yoe_next = (r8_yr >= e2lct_pkg::DAYS_PER_YEAR) ? s7_ye_reg + 9'd1 : s7_ye_reg;

        // stage 9: day of year, March based
        c100  = 2'(s8_yoe_reg >= 9'd100) + 2'(s8_yoe_reg >= 9'd200)
              + 2'(s8_yoe_reg >= 9'd300);
        ydays = 18'(s8_yoe_reg) * e2lct_pkg::DAYS_PER_YEAR
              + 18'(s8_yoe_reg[8:2]) - 18'(c100);
        r9          = s8_doe_reg - ydays;
        s9_doy_next = r9[8:0];

        // stage 10: month by table search, then day and year
        mp = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (s9_doy_reg >= e2lct_pkg::month_start(4'(k)))
                mp = mp + 4'd1;
        end
        ms  = e2lct_pkg::month_start(mp);
        mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        s10_out_next.month   = mon;
        s10_out_next.day     = 5'(s9_doy_reg - ms + 9'd1);
        s10_out_next.year    = 12'(s9_yoe_reg)
                             + (s9_era5_reg ? e2lct_pkg::YEAR_ERA5 : e2lct_pkg::YEAR_ERA4)
                             + 12'(mon <= 4'd2);
        s10_out_next.hour    = s9_hour_reg;
        s10_out_next.minute  = s9_min_reg;
        s10_out_next.second  = s9_sec_reg;
        s10_out_next.weekday = s9_wd_reg;
    end

    // advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg      <= s1_t_next;
            s2_t_reg      <= s1_t_reg;
            s2_dq_reg     <= s2_dq_next;
            s3_days_reg   <= s3_days_next;
            s3_secs_reg   <= s3_secs_next;
            s4_doe_reg    <= s4_doe_next;
            s4_era5_reg   <= s4_era5_next;
            s4_d4_reg     <= s4_d4_next;
            s4_wq_reg     <= s4_wq_next;
            s4_secs_reg   <= s3_secs_reg;
            s4_hq_reg     <= s4_hq_next;
            s5_doe_reg    <= s4_doe_reg;
            s5_era5_reg   <= s4_era5_reg;
            s5_q4y_reg    <= s5_q4y_next;
            s5_c100y_reg  <= s5_c100y_next;
            s5_last_reg   <= s5_last_next;
            s5_wd_reg     <= s5_wd_next;
            s5_hour_reg   <= s5_hour_next;
            s5_rem_reg    <= s5_rem_next;
            s6_doe_reg    <= s5_doe_reg;
            s6_era5_reg   <= s5_era5_reg;
            s6_n_reg      <= s6_n_next;
            s6_wd_reg     <= s5_wd_reg;
            s6_hour_reg   <= s5_hour_reg;
            s6_rem_reg    <= s5_rem_reg;
            s6_mq_reg     <= s6_mq_next;
            s7_doe_reg    <= s6_doe_reg;
            s7_era5_reg   <= s6_era5_reg;
            s7_n_reg      <= s6_n_reg;
            s7_ye_reg     <= s7_ye_next;
            s7_wd_reg     <= s6_wd_reg;
            s7_hour_reg   <= s6_hour_reg;
            s7_min_reg    <= s7_min_next;
            s7_sec_reg    <= s7_sec_next;
            s8_doe_reg    <= s7_doe_reg;
            s8_era5_reg   <= s7_era5_reg;
            s8_yoe_reg    <= s8_yoe_next;
            s8_wd_reg     <= s7_wd_reg;
            s8_hour_reg   <= s7_hour_reg;
            s8_min_reg    <= s7_min_reg;
            s8_sec_reg    <= s7_sec_reg;
            s9_era5_reg   <= s8_era5_reg;
            s9_yoe_reg    <= s8_yoe_reg;
            s9_doy_reg    <= s9_doy_next;
            s9_wd_reg     <= s8_wd_reg;
            s9_hour_reg   <= s8_hour_reg;
            s9_min_reg    <= s8_min_reg;
            s9_sec_reg    <= s8_sec_reg;
            s10_out_reg   <= s10_out_next;
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {7'd0, s10_out_reg};

    // checks
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && !en |=> skid_vld_reg)
        else $error("skid word dropped during stall");

    a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> s3_secs_reg < e2lct_pkg::SECS_PER_DAY)
        else $error("seconds of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (s10_out_reg.month >= 4'd1 && s10_out_reg.month <= 4'd12
                           && s10_out_reg.day >= 5'd1 && s10_out_reg.day <= 5'd31))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (s10_out_reg.hour <= 5'd23 && s10_out_reg.minute <= 6'd59
                           && s10_out_reg.second <= 6'd59 && s10_out_reg.weekday <= 3'd6))
        else $error("time of day or weekday out of range");

endmodule

`default_nettype wire
